@@ rtl/slrc_pkg.sv @@
// Package with the shared constants, codes and types of the left-right consistency check.
package slrc_pkg;

   // Row store geometry and fixed point format.
   localparam int MAX_WIDTH = 4096;
   localparam int FRAC_BITS = 4;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);

   // Field widths.
   localparam int COL_W   = 12;
   localparam int DISP_W  = 13;
   localparam int THR_W   = 12;
   localparam int RWID_W  = 13;
   localparam int ENTRY_W = DISP_W + 1;

   // Datapath widths: column scaled plus disparity, rounded column, mismatch.
   localparam int SUM_W  = COL_W + FRAC_BITS + 2;
   localparam int LX_W   = SUM_W - FRAC_BITS;
   localparam int DIFF_W = LX_W + FRAC_BITS + 2;

   // Rounding offsets, halves away from zero.
   localparam int ROUND_POS = (1 << FRAC_BITS) >> 1;
   localparam int ROUND_NEG = (1 << FRAC_BITS) - 1 - ROUND_POS;

   // Register reset values.
   localparam logic [THR_W-1:0]  THRESHOLD_RST   = THR_W'(16);
   localparam logic              MASK_ONLY_RST   = 1'b0;
   localparam logic [RWID_W-1:0] RIGHT_WIDTH_RST = RWID_W'(4096);

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_THRESHOLD   = 2'd0,
      REG_MASK_ONLY   = 2'd1,
      REG_RIGHT_WIDTH = 2'd2
   } reg_idx_type;

   // Item kinds on the request channel.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   // Request from the pipeline to the row store.
   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [ENTRY_W-1:0] wdata;
      logic               re;
      logic [ADDR_W-1:0]  raddr;
   } ram_req_type;

endpackage

@@ rtl/slrc_row_store.sv @@
// Right-row disparity store: one write port and one registered read port.
module slrc_row_store (
   input  logic                          clock,
   input  slrc_pkg::ram_req_type         req,
   output logic [slrc_pkg::ENTRY_W-1:0]  rdata
);

   logic [slrc_pkg::ENTRY_W-1:0] mem [slrc_pkg::MAX_WIDTH];
   logic [slrc_pkg::ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/stereo_left_right_check.sv @@
// Top level of the left-right disparity consistency check for one image row.
//
// Usage: the request channel carries two kinds of transaction, told apart by
// req_tuser. A load transaction writes one right-row disparity and its valid
// flag into the row store and gives no response. A check transaction carries a
// left pixel's column and disparity; the block rounds column plus disparity to
// the nearest right column, reads that entry and marks the pixel occluded when
// the left disparity is invalid, the column falls outside the right row width,
// the right entry is invalid, or the two disparities disagree by more than the
// threshold. Each check transaction gives exactly one response transaction.
// A response passes through the stage registers in order, from stage 1 to the
// response register. Throughput is one transaction per cycle of either kind
// while the response side does not stall, set by the single read port and single
// write port of the row store, which both serve the same pipeline stage.
// Reset clears the pipeline valid bits and loads the register defaults
// (threshold 16, mask-only off, right width 4096). The row store has no reset:
// every entry must be loaded before a check reads it.
// When the receiver stalls, the whole five-stage pipeline holds in place and req_tready drops
// in the same cycle; nothing is lost or repeated. The user must write registers over the
// APB-style port only while the block is idle; the block itself does not enforce this.
module stereo_left_right_check (
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // column [11:0], disp [24:12], disp_valid [25], zero [31:26]
   input  logic [0:0]  req_tuser,   // op [0]

   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // occluded [0], out_disp [13:1], out_valid [14], zero [15]

   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [slrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [slrc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [slrc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [slrc_pkg::THR_W-1:0]  threshold_ff,   threshold_in;
   logic                        mask_only_ff,   mask_only_in;
   logic [slrc_pkg::RWID_W-1:0] right_width_ff, right_width_in;
   logic                        csr_wr;
   slrc_pkg::reg_idx_type       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = slrc_pkg::reg_idx_type'(csr_paddr[slrc_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      threshold_in   = threshold_ff;
      mask_only_in   = mask_only_ff;
      right_width_in = right_width_ff;
      csr_prdata     = '0;
      unique case (csr_idx)
         slrc_pkg::REG_THRESHOLD: begin
            csr_prdata = slrc_pkg::CSR_DATA_W'(threshold_ff);
            if (csr_wr) threshold_in = csr_pwdata[slrc_pkg::THR_W-1:0];
         end
         slrc_pkg::REG_MASK_ONLY: begin
            csr_prdata = slrc_pkg::CSR_DATA_W'(mask_only_ff);
            if (csr_wr) mask_only_in = csr_pwdata[0];
         end
         slrc_pkg::REG_RIGHT_WIDTH: begin
            csr_prdata = slrc_pkg::CSR_DATA_W'(right_width_ff);
            if (csr_wr) right_width_in = csr_pwdata[slrc_pkg::RWID_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= slrc_pkg::THRESHOLD_RST;
         mask_only_ff   <= slrc_pkg::MASK_ONLY_RST;
         right_width_ff <= slrc_pkg::RIGHT_WIDTH_RST;
      end else begin
         threshold_ff   <= threshold_in;
         mask_only_ff   <= mask_only_in;
         right_width_ff <= right_width_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control. Every stage moves together; the response register
   // is the only place where a finished result waits.
   // ------------------------------------------------------------------
   logic adv;
   logic rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // ------------------------------------------------------------------
   // Stage 1: registered request.
   // ------------------------------------------------------------------
   logic                               s1_vld_ff;
   slrc_pkg::op_type                   s1_op_ff;
   logic [slrc_pkg::COL_W-1:0]         s1_col_ff;
   logic signed [slrc_pkg::DISP_W-1:0] s1_disp_ff;
   logic                               s1_dval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff   <= slrc_pkg::op_type'(req_tuser[0]);
         s1_col_ff  <= req_tdata[slrc_pkg::COL_W-1:0];
         s1_disp_ff <= $signed(req_tdata[slrc_pkg::COL_W +: slrc_pkg::DISP_W]);
         s1_dval_ff <= req_tdata[slrc_pkg::COL_W + slrc_pkg::DISP_W];
      end
   end

   // Scaled column plus disparity, rounded to the nearest whole column.
   // The negative offset is the fraction mask less half a column, so an
   // arithmetic shift rounds halves away from zero.
   logic signed [slrc_pkg::SUM_W-1:0] s1_col_ext;
   logic signed [slrc_pkg::SUM_W-1:0] s1_sum;
   logic signed [slrc_pkg::SUM_W-1:0] s1_rnd;
   logic signed [slrc_pkg::LX_W-1:0]  s1_lx;

   always_comb begin
      s1_col_ext = $signed({{(slrc_pkg::SUM_W-slrc_pkg::COL_W){1'b0}}, s1_col_ff});
      s1_sum     = (s1_col_ext <<< slrc_pkg::FRAC_BITS) + slrc_pkg::SUM_W'(s1_disp_ff);
      s1_rnd     = s1_sum + (s1_sum[slrc_pkg::SUM_W-1] ?
                             $signed(slrc_pkg::SUM_W'(slrc_pkg::ROUND_NEG)) :
                             $signed(slrc_pkg::SUM_W'(slrc_pkg::ROUND_POS)));
      s1_lx      = slrc_pkg::LX_W'(s1_rnd >>> slrc_pkg::FRAC_BITS);
   end

   // ------------------------------------------------------------------
   // Stage 2: range check, row store write for loads and read for checks.
   // ------------------------------------------------------------------
   logic                               s2_vld_ff;
   slrc_pkg::op_type                   s2_op_ff;
   logic [slrc_pkg::COL_W-1:0]         s2_col_ff;
   logic signed [slrc_pkg::DISP_W-1:0] s2_disp_ff;
   logic                               s2_dval_ff;
   logic signed [slrc_pkg::LX_W-1:0]   s2_lx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff   <= s1_op_ff;
         s2_col_ff  <= s1_col_ff;
         s2_disp_ff <= s1_disp_ff;
         s2_dval_ff <= s1_dval_ff;
         s2_lx_ff   <= s1_lx;
      end
   end

   logic [31:0]                   s2_lx_u;
   logic                          s2_in_range;
   logic                          s2_occl;
   slrc_pkg::ram_req_type         ram_req;
   logic [slrc_pkg::ENTRY_W-1:0]  ram_rdata;

   always_comb begin
      s2_lx_u     = 32'($unsigned(s2_lx_ff));
      s2_in_range = !s2_lx_ff[slrc_pkg::LX_W-1] &&
                    (s2_lx_u < 32'(right_width_ff)) &&
                    (s2_lx_u < 32'(slrc_pkg::MAX_WIDTH));
      s2_occl     = !s2_dval_ff || !s2_in_range;

      // Loads and checks use the store from the same stage, so a check
      // always sees every load that was accepted before it.
      ram_req.we    = adv && s2_vld_ff && (s2_op_ff == slrc_pkg::OP_LOAD) &&
                      (32'(s2_col_ff) < 32'(slrc_pkg::MAX_WIDTH));
      ram_req.waddr = slrc_pkg::ADDR_W'(s2_col_ff);
      ram_req.wdata = {s2_dval_ff, s2_disp_ff};
      ram_req.re    = adv;
      ram_req.raddr = slrc_pkg::ADDR_W'($unsigned(s2_lx_ff));
   end

   slrc_row_store u_row_store (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Stage 3: right entry arrives; form the signed mismatch.
   // Only checks travel on from here.
   // ------------------------------------------------------------------
   logic                               s3_vld_ff;
   logic [slrc_pkg::COL_W-1:0]         s3_col_ff;
   logic signed [slrc_pkg::DISP_W-1:0] s3_disp_ff;
   logic                               s3_dval_ff;
   logic signed [slrc_pkg::LX_W-1:0]   s3_lx_ff;
   logic                               s3_occl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff && (s2_op_ff == slrc_pkg::OP_CHECK);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_col_ff  <= s2_col_ff;
         s3_disp_ff <= s2_disp_ff;
         s3_dval_ff <= s2_dval_ff;
         s3_lx_ff   <= s2_lx_ff;
         s3_occl_ff <= s2_occl;
      end
   end

   logic signed [slrc_pkg::DIFF_W-1:0] s3_col_ext;
   logic signed [slrc_pkg::DIFF_W-1:0] s3_rdisp;
   logic signed [slrc_pkg::DIFF_W-1:0] s3_diff;
   logic                               s3_occl;

   always_comb begin
      s3_col_ext = $signed({{(slrc_pkg::DIFF_W-slrc_pkg::COL_W){1'b0}}, s3_col_ff});
      s3_rdisp   = slrc_pkg::DIFF_W'($signed(ram_rdata[slrc_pkg::DISP_W-1:0]));
      s3_diff    = ((slrc_pkg::DIFF_W'(s3_lx_ff) - s3_col_ext) <<< slrc_pkg::FRAC_BITS) +
                   s3_rdisp;
      s3_occl    = s3_occl_ff || !ram_rdata[slrc_pkg::ENTRY_W-1];
   end

   // ------------------------------------------------------------------
   // Stage 4: compare the mismatch with the threshold and build the result.
   // ------------------------------------------------------------------
   logic                               s4_vld_ff;
   logic signed [slrc_pkg::DISP_W-1:0] s4_disp_ff;
   logic                               s4_dval_ff;
   logic signed [slrc_pkg::DIFF_W-1:0] s4_diff_ff;
   logic                               s4_occl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_disp_ff <= s3_disp_ff;
         s4_dval_ff <= s3_dval_ff;
         s4_diff_ff <= s3_diff;
         s4_occl_ff <= s3_occl;
      end
   end

   logic signed [slrc_pkg::DIFF_W-1:0] s4_thr;
   logic                               s4_occl;
   logic                               s4_keep;

   always_comb begin
      s4_thr  = $signed({{(slrc_pkg::DIFF_W-slrc_pkg::THR_W){1'b0}}, threshold_ff});
      // The absolute mismatch exceeds the threshold exactly when the signed
      // mismatch lies above it or below its negative.
      s4_occl = s4_occl_ff || (s4_diff_ff > s4_thr) || (s4_diff_ff < -s4_thr);
      s4_keep = s4_dval_ff && (!s4_occl || mask_only_ff);
   end

   // ------------------------------------------------------------------
   // Stage 5: response register.
   // ------------------------------------------------------------------
   logic                        rsp_occl_ff;
   logic [slrc_pkg::DISP_W-1:0] rsp_disp_ff;
   logic                        rsp_oval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_occl_ff <= s4_occl;
         rsp_disp_ff <= s4_keep ? $unsigned(s4_disp_ff) : '0;
         rsp_oval_ff <= s4_keep;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_oval_ff, rsp_disp_ff, rsp_occl_ff};

endmodule

@@ rtl/slrc_checker.sv @@
// Port-level assertions for the consistency check, bound to the top level.
module slrc_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An invalid result always carries a zero disparity.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[14] |-> rsp_tdata[13:1] == 13'd0)
      else $error("invalid result with nonzero disparity");

   // The request side only backs off when a response is stuck.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a response stall");

endmodule

bind stereo_left_right_check slrc_port_checker u_slrc_port_checker (.*);
